@@ hdl/pwmt_pkg.sv @@
// Shared types, constants and op codes for the four-channel PWM timer.
package pwmt_pkg;

    localparam int CHANNELS   = 4;
    localparam int COUNT_BITS = 16;
    localparam int CH_BITS    = 3;
    localparam int IDX_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0]  PCT_FULL      = 7'd100;
    localparam logic [15:0] PERIOD_RESET  = 16'd1000;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SET     = 3'd1,
        OP_GET     = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4,
        OP_FORCE   = 3'd5,
        OP_NONE6   = 3'd6,
        OP_NONE7   = 3'd7
    } t_op;

    typedef enum logic {
        CFG_PRESCALE = 1'b0,
        CFG_PERIOD   = 1'b1
    } t_cfg_idx;

    // Classified item handed from front to back.
    typedef struct packed {
        t_op                 op;
        logic                bad;
        logic [IDX_BITS-1:0] idx;
        logic [6:0]          duty;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

@@ hdl/pwmt_front.sv @@
// Front end: accept items, clamp duty, check channel, and queue them.
module pwmt_front
    import pwmt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [2:0]   i_op,
    input  logic [2:0]   i_channel,
    input  logic [7:0]   i_duty,
    output logic         o_cmd_valid,
    input  logic         i_cmd_ready,
    output t_cmd         o_cmd
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    t_cmd                r_q [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [PTR_BITS:0]   r_cnt;
    logic                push, pop;
    logic                ch_ok;
    t_cmd                cls;

    always_comb begin
        ch_ok    = (i_channel >= 3'd1) && ({29'd0, i_channel} <= CHANNELS);
        cls.op   = t_op'(i_op);
        cls.bad  = ((i_op >= OP_SET) && (i_op <= OP_DISABLE)) && !ch_ok;
        cls.idx  = ch_ok ? IDX_BITS'(i_channel - 3'd1) : '0;
        cls.duty = (i_duty > 8'(PCT_FULL)) ? PCT_FULL : i_duty[6:0];
    end

    assign o_ready     = (r_cnt != (PTR_BITS+1)'(QUEUE_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
        end
    end

endmodule

@@ hdl/pwmt_back.sv @@
// Back end: timer state, multiply-divide sequencer and result register.
module pwmt_back
    import pwmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_prescale,
    input  logic [15:0]           i_period,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  t_cmd                  i_cmd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [3:0]            o_pwm_out,
    output logic [6:0]            o_read_duty,
    output logic                  o_bad_request
);

    localparam int PROD_BITS = COUNT_BITS + 7;
    localparam int QBITS     = COUNT_BITS + 7;
    localparam int DIV_BITS  = $clog2(QBITS + 1);
    // Divide by 100 as multiply by ceil(2^30/100), exact for numerators below 2^23.
    localparam int          RECIP_SHIFT   = 30;
    localparam int          RECIP_BITS    = 24;
    localparam logic [23:0] PCT_RECIP     = 24'd10737419;
    localparam int          SET_PROD_BITS = PROD_BITS + RECIP_BITS;

    logic [15:0]           r_pcount;
    logic [COUNT_BITS-1:0] r_mcount;
    logic [COUNT_BITS-1:0] r_pre [CHANNELS];
    logic [COUNT_BITS-1:0] r_act [CHANNELS];
    logic [CHANNELS-1:0]   r_en;

    t_back_state           r_state, n_state;
    t_cmd                  r_cmd;
    logic [PROD_BITS-1:0]  r_prod;
    logic [PROD_BITS-1:0]  r_rem;
    logic [QBITS-1:0]      r_quo;
    logic [DIV_BITS-1:0]   r_step;

    logic                  r_out_v;
    logic [3:0]            r_pwm;
    logic [6:0]            r_rd;
    logic                  r_bad;

    logic [COUNT_BITS-1:0] top;
    logic                  take, out_free, finish;
    logic [PROD_BITS-1:0]  rem_sh, divisor;
    logic [SET_PROD_BITS-1:0] set_prod;
    logic [6:0]            rd_val;
    logic [CHANNELS-1:0]   lv;
    logic                  do_tick, do_load, do_zero;

    assign top      = COUNT_BITS'(i_period);
    assign out_free = !r_out_v || i_ready;
    assign divisor  = PROD_BITS'(top);
    assign set_prod = SET_PROD_BITS'(r_prod) * SET_PROD_BITS'(PCT_RECIP);

    // Sequencer: simple ops go straight from ST_IDLE to ST_DONE; set/get go through mul, div.
    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        take        = 1'b0;
        finish      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                take = i_cmd_valid;
                if (take && !i_cmd.bad &&
                    (i_cmd.op == OP_SET || i_cmd.op == OP_GET)) begin
                    n_state = ST_MUL;
                end else if (take) begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_cmd.op == OP_SET || r_step == DIV_BITS'(QBITS - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign rem_sh = {r_rem[PROD_BITS-2:0], r_prod[PROD_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (take) r_cmd <= i_cmd;
        unique case (r_state)
            ST_MUL: begin
                // numerator: period*duty for set, compare*100 for get
                if (r_cmd.op == OP_SET) begin
                    r_prod <= PROD_BITS'(top) * PROD_BITS'(r_cmd.duty);
                end else begin
                    r_prod <= PROD_BITS'(r_pre[r_cmd.idx]) * PROD_BITS'(PCT_FULL);
                end
                r_rem  <= '0;
                r_quo  <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                if (r_cmd.op == OP_SET) begin
                    r_quo <= QBITS'(set_prod[SET_PROD_BITS-1:RECIP_SHIFT]);
                end else begin
                    // one restoring step per cycle
                    if (divisor != '0 && rem_sh >= divisor) begin
                        r_rem <= rem_sh - divisor;
                        r_quo <= {r_quo[QBITS-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[QBITS-2:0], 1'b0};
                    end
                    r_prod <= {r_prod[PROD_BITS-2:0], 1'b0};
                    r_step <= r_step + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        do_tick = finish && !r_cmd.bad && r_cmd.op == OP_TICK;
        do_zero = finish && !r_cmd.bad && r_cmd.op == OP_FORCE;
        do_load = do_zero ||
                  (do_tick && r_pcount >= i_prescale && r_mcount >= top);
        if (top == '0) begin
            rd_val = '0;
        end else if (r_quo > QBITS'(PCT_FULL)) begin
            rd_val = PCT_FULL;
        end else begin
            rd_val = r_quo[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pcount <= '0;
            r_mcount <= '0;
            r_en     <= '0;
            r_out_v  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_pre[i] <= '0;
                r_act[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            if (finish) r_out_v <= 1'b1;
            if (do_zero) begin
                r_pcount <= '0;
                r_mcount <= '0;
            end else if (do_tick) begin
                if (r_pcount >= i_prescale) begin
                    r_pcount <= '0;
                    r_mcount <= (r_mcount >= top) ? '0 : r_mcount + 1'b1;
                end else begin
                    r_pcount <= r_pcount + 1'b1;
                end
            end
            if (do_load) begin
                for (int i = 0; i < CHANNELS; i++) r_act[i] <= r_pre[i];
            end
            if (finish && !r_cmd.bad) begin
                if (r_cmd.op == OP_SET) r_pre[r_cmd.idx] <= r_quo[COUNT_BITS-1:0];
                if (r_cmd.op == OP_ENABLE)  r_en[r_cmd.idx] <= 1'b1;
                if (r_cmd.op == OP_DISABLE) r_en[r_cmd.idx] <= 1'b0;
            end
        end
    end

    // Output levels follow the state after the item; compute from next values.
    logic [COUNT_BITS-1:0] nx_mcount;
    logic [COUNT_BITS-1:0] nx_act [CHANNELS];
    logic [CHANNELS-1:0]   nx_en;

    always_comb begin
        nx_mcount = r_mcount;
        if (do_zero) begin
            nx_mcount = '0;
        end else if (do_tick && r_pcount >= i_prescale) begin
            nx_mcount = (r_mcount >= top) ? '0 : r_mcount + 1'b1;
        end
        nx_en = r_en;
        if (finish && !r_cmd.bad && r_cmd.op == OP_ENABLE)  nx_en[r_cmd.idx] = 1'b1;
        if (finish && !r_cmd.bad && r_cmd.op == OP_DISABLE) nx_en[r_cmd.idx] = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            nx_act[i] = do_load ? r_pre[i] : r_act[i];
            lv[i] = nx_en[i] && (nx_mcount < nx_act[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_pwm <= 4'(lv);
            r_rd  <= (!r_cmd.bad && r_cmd.op == OP_GET) ? rd_val : 7'd0;
            r_bad <= r_cmd.bad;
        end
    end

    assign o_valid       = r_out_v;
    assign o_pwm_out     = r_pwm;
    assign o_read_duty   = r_rd;
    assign o_bad_request = r_bad;

endmodule

@@ hdl/four_channel_pwm_timer.sv @@
// Top level of the four-channel PWM timer: config registers, front and back.
//
// Items enter a two-entry queue and are carried out one at a time. Tick, enable,
// disable, force update and rejected items go through the back end as take, then
// result. Set duty goes through take, multiply, a reciprocal multiply for the
// divide by 100, then result. Get duty goes through take, multiply, a restoring
// divide that retires one quotient bit per cycle over 23 bits, then result.
// Results sit in an output register, so the queue keeps filling while a result
// waits to be taken.
module four_channel_pwm_timer
    import pwmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [2:0]  i_channel,
    input  logic [7:0]  i_duty,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_pwm_out,
    output logic [6:0]  o_read_duty,
    output logic        o_bad_request
);

    logic [15:0] r_prescale;
    logic [15:0] r_period;
    logic        cmd_valid, cmd_ready;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_period   <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRESCALE: r_prescale <= i_cfg_data;
                CFG_PERIOD:   r_period   <= i_cfg_data;
            endcase
        end
    end

    pwmt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_channel   (i_channel),
        .i_duty      (i_duty),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    pwmt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_prescale    (r_prescale),
        .i_period      (r_period),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_ready   (cmd_ready),
        .i_cmd         (cmd),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pwm_out     (o_pwm_out),
        .o_read_duty   (o_read_duty),
        .o_bad_request (o_bad_request)
    );

    a_bad_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_request |-> o_read_duty == 7'd0)
        else $error("rejected item carries a duty reading");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_read_duty <= PCT_FULL)
        else $error("duty reading above full scale");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule
